@@ rtl/bounded_stack_with_search_assert.svh @@
// assertion macros for the bounded stack
`ifndef BOUNDED_STACK_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_STACK_WITH_SEARCH_ASSERT_SVH
`ifndef SYNTH
`define BSS_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("bss assertion failed");
`define BSS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("bss assertion failed");
`else
`define BSS_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define BSS_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

@@ rtl/bss_pkg.sv @@
`timescale 1ns / 1ps
package bss_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 6;

    localparam logic [CFG_W-1:0] LIMIT_RESET = 6'd32;

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;
    localparam logic [1:0] MODE_DUMP  = 2'd3;

    localparam logic [2:0] ST_PUSHED     = 3'd0;
    localparam logic [2:0] ST_OVERFLOW   = 3'd1;
    localparam logic [2:0] ST_POPPED     = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW  = 3'd3;
    localparam logic [2:0] ST_FOUND      = 3'd4;
    localparam logic [2:0] ST_NOTFOUND   = 3'd5;
    localparam logic [2:0] ST_DUMP_ENTRY = 3'd6;
    localparam logic [2:0] ST_DUMP_EMPTY = 3'd7;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] result_value;
        logic                     last;
    } rsp_t;

endpackage

@@ rtl/bss_out_reg.sv @@
`timescale 1ns / 1ps
module bss_out_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  bss_pkg::rsp_t load_item,
    output logic          free,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bss_pkg::rsp_t rsp
);

    logic          valid_reg;
    logic          valid_next;
    bss_pkg::rsp_t item_reg;

    // slot can take a new result if empty or being drained this cycle
    assign free = !valid_reg || !rsp_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = item_reg;

endmodule

@@ rtl/bounded_stack_with_search.sv @@
`timescale 1ns / 1ps
// channel   | handshake               | payload
// ----------+-------------------------+-----------------------------
// cmd       | cmd_valid / cmd_stall   | bss_pkg::cmd_t (mode, value)
// rsp       | rsp_valid / rsp_stall   | bss_pkg::rsp_t (status, result_value, last)
// cfg       | cfg_wen                 | cfg_wdata (depth limit)
//
// push, overflow, underflow, empty query, empty dump: result registered, then loaded
// pop: top entry read first; query: compares one entry per cycle from the top
// dump: entries read one at a time through the single registered read port of the
// entry memory; cmd_stall is high until the last result is loaded for output
// reset clears the count and sets the limit to 32; entries are not cleared
// rsp_stall holds the result register and the sequencer waits until it drains
module bounded_stack_with_search #(
    parameter int DEPTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_stall,
    input  bss_pkg::cmd_t             cmd,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output bss_pkg::rsp_t             rsp,
    input  logic                      cfg_wen,
    input  logic [bss_pkg::CFG_W-1:0] cfg_wdata
);

`include "bounded_stack_with_search_assert.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > bss_pkg::CFG_W) ? CW : bss_pkg::CFG_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_POP  = 5'b00010,
        S_SCAN = 5'b00100,
        S_DUMP = 5'b01000,
        S_PUT  = 5'b10000
    } state_t;

    state_t                      state_reg, state_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [bss_pkg::CFG_W-1:0]   limit_reg;
    logic                        dump_reg, dump_next;
    logic [AW-1:0]               idx_reg, idx_next;
    logic [bss_pkg::DATA_W-1:0]  word_reg, word_next;
    bss_pkg::rsp_t               res_reg, res_next;
    logic [bss_pkg::DATA_W-1:0]  rd_data_reg;
    logic [bss_pkg::DATA_W-1:0]  mem [DEPTH];

    logic          accept;
    logic          full;
    logic          empty;
    logic [AW-1:0] top_idx;
    logic [AW-1:0] idx_dec;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic          rd_en;
    logic          load;
    logic          free;

    assign cmd_stall = (state_reg != S_IDLE);
    assign accept    = cmd_valid && (state_reg == S_IDLE);

    // a limit above the depth acts as the depth
    assign full    = (count_reg >= CW'(DEPTH)) || (LW'(count_reg) >= LW'(limit_reg));
    assign empty   = (count_reg == '0);
    assign top_idx = AW'(count_reg - CW'(1));
    assign idx_dec = idx_reg - AW'(1);
    assign wr_addr = count_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        dump_next  = dump_reg;
        idx_next   = idx_reg;
        word_next  = word_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        load       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    word_next           = cmd.value;
                    dump_next           = 1'b0;
                    res_next.last       = 1'b1;
                    res_next.result_value = '0;
                    state_next          = S_PUT;
                    case (cmd.mode)
                        bss_pkg::MODE_PUSH:
                        begin
                            if (full)
                            begin
                                res_next.status = bss_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                wr_en                 = 1'b1;
                                count_next            = count_reg + CW'(1);
                                res_next.status       = bss_pkg::ST_PUSHED;
                                res_next.result_value = cmd.value;
                            end
                        end
                        bss_pkg::MODE_POP:
                        begin
                            if (empty)
                            begin
                                res_next.status = bss_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                rd_en      = 1'b1;
                                rd_addr    = top_idx;
                                state_next = S_POP;
                            end
                        end
                        bss_pkg::MODE_QUERY:
                        begin
                            if (empty)
                            begin
                                res_next.status       = bss_pkg::ST_NOTFOUND;
                                res_next.result_value = cmd.value;
                            end
                            else
                            begin
                                idx_next   = top_idx;
                                rd_en      = 1'b1;
                                rd_addr    = top_idx;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            if (empty)
                            begin
                                res_next.status = bss_pkg::ST_DUMP_EMPTY;
                            end
                            else
                            begin
                                idx_next   = top_idx;
                                dump_next  = 1'b1;
                                rd_en      = 1'b1;
                                rd_addr    = top_idx;
                                state_next = S_DUMP;
                            end
                        end
                    endcase
                end
            end
            S_POP:
            begin
                res_next.status       = bss_pkg::ST_POPPED;
                res_next.result_value = rd_data_reg;
                res_next.last         = 1'b1;
                state_next            = S_PUT;
            end
            S_SCAN:
            begin
                // one compare per cycle, walking down from the top
                if (rd_data_reg == word_reg)
                begin
                    res_next.status       = bss_pkg::ST_FOUND;
                    res_next.result_value = word_reg;
                    res_next.last         = 1'b1;
                    state_next            = S_PUT;
                end
                else if (idx_reg == '0)
                begin
                    res_next.status       = bss_pkg::ST_NOTFOUND;
                    res_next.result_value = word_reg;
                    res_next.last         = 1'b1;
                    state_next            = S_PUT;
                end
                else
                begin
                    idx_next = idx_dec;
                    rd_en    = 1'b1;
                    rd_addr  = idx_dec;
                end
            end
            S_DUMP:
            begin
                res_next.status       = bss_pkg::ST_DUMP_ENTRY;
                res_next.result_value = rd_data_reg;
                res_next.last         = (idx_reg == '0);
                state_next            = S_PUT;
            end
            S_PUT:
            begin
                if (free)
                begin
                    load = 1'b1;
                    if (dump_reg && !res_reg.last)
                    begin
                        idx_next   = idx_dec;
                        rd_en      = 1'b1;
                        rd_addr    = idx_dec;
                        state_next = S_DUMP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            limit_reg <= bss_pkg::LIMIT_RESET;
            dump_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            dump_reg  <= dump_next;
            if (cfg_wen)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        word_reg <= word_next;
        res_reg  <= res_next;
    end

    // entry memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    bss_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_item (res_reg),
        .free      (free),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    `BSS_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH))
    `BSS_ASSERT_NEXT(a_pop_count, clk, rst_n,
        accept && cmd.mode == bss_pkg::MODE_POP && !empty,
        count_reg == $past(count_reg) - CW'(1))
    `BSS_ASSERT_NEXT(a_put_wait, clk, rst_n,
        state_reg == S_PUT && !free,
        state_reg == S_PUT && $stable(res_reg))

endmodule
